@@ rtl/tkr_pkg.sv @@
`default_nettype none
package tkr_pkg;

  // Key space and counter sizing
  localparam int NUM_KEYS  = 64;
  localparam int KEY_W     = 6;
  localparam int KEY_SPACE = 1 << KEY_W;
  localparam int CNT_W     = $clog2(NUM_KEYS + 1);
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 64;

  // Register map (index of an 8-byte slot)
  localparam logic REG_KEY_MASK = 1'b0;

  // Reported event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_t;

  // Input command codes
  localparam logic CMD_RELEASE = 1'b0;
  localparam logic CMD_PRESS   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the input item and update key state
    logic advance;  // switch the output register to the pending press
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic second_pending;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/tkr_ctrl.sv @@
`default_nettype none
module tkr_ctrl import tkr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd_o
);

  ctl_state_t state, state_next;

  // Hold the controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one item: take it, then hand out one or two results
  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.advance = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.second_pending) begin
            cmd_o.advance = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/tkr_datapath.sv @@
`default_nettype none
module tkr_datapath import tkr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd_i,
  output dp_status_t             status,
  input  wire logic              cfg_write,
  input  wire logic [DATA_W-1:0] cfg_data,
  output logic [DATA_W-1:0]      key_mask,
  input  wire logic              cmd,
  input  wire logic [KEY_W-1:0]  key_index,
  output logic [1:0]             event_kind,
  output logic [KEY_W-1:0]       out_key,
  output logic                   accepted,
  output logic                   last
);

  logic [KEY_SPACE-1:0] held, held_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [KEY_W-1:0]     recog, recog_next;
  logic [KEY_W-1:0]     pend_key;
  logic                 pending;

  logic [KEY_SPACE-1:0] key_bit;
  logic                 in_range, exists, hit;
  logic [KEY_W-1:0]     rest;
  ev_kind_t             r_kind;
  logic [KEY_W-1:0]     r_key;
  logic                 r_last, r_two;

  // Encode a word that holds at most one set bit
  function automatic logic [KEY_W-1:0] onehot_index(input logic [KEY_SPACE-1:0] v);
    logic [KEY_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < KEY_SPACE; k++) begin
      if (v[k]) idx = idx | KEY_W'(k);
    end
    return idx;
  endfunction

  // Decode the event against the present mask and the held set
  always_comb begin
    key_bit    = KEY_SPACE'(1) << key_index;
    in_range   = {1'b0, key_index} < (KEY_W + 1)'(NUM_KEYS);
    exists     = in_range && key_mask[key_index];
    hit        = held[key_index];
    held_next  = held;
    count_next = count;
    recog_next = recog;
    r_kind     = EV_NONE;
    r_key      = '0;
    r_last     = 1'b1;
    r_two      = 1'b0;
    rest       = '0;
    if (exists) begin
      if (cmd == CMD_PRESS) begin
        if (!hit) begin
          held_next  = held | key_bit;
          count_next = count + CNT_W'(1);
          if (count == '0) begin
            recog_next = key_index;
            r_kind     = EV_PRESS;
            r_key      = key_index;
          end
        end
      end else if (hit) begin
        held_next  = held & ~key_bit;
        count_next = count - CNT_W'(1);
        // one key left means one bit left: encode it directly
        rest       = onehot_index(held_next);
        if (count == CNT_W'(1)) begin
          r_kind = EV_RELEASE;
        end else if (count == CNT_W'(2) && rest != recog) begin
          recog_next = rest;
          r_kind     = EV_RELEASE;
          r_last     = 1'b0;
          r_two      = 1'b1;
        end
      end
    end
  end

  // Hold the present mask
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask <= '1;
    end else if (cfg_write) begin
      key_mask <= cfg_data;
    end
  end

  // Update the key state on each loaded item
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      count   <= '0;
      recog   <= '0;
      pending <= 1'b0;
    end else if (cmd_i.load) begin
      held    <= held_next;
      count   <= count_next;
      recog   <= recog_next;
      pending <= r_two;
    end else if (cmd_i.advance) begin
      pending <= 1'b0;
    end
  end

  // Load the result register, then swap in the pending press
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      event_kind <= r_kind;
      out_key    <= r_key;
      accepted   <= exists;
      last       <= r_last;
      pend_key   <= rest;
    end else if (cmd_i.advance) begin
      event_kind <= EV_PRESS;
      out_key    <= pend_key;
      last       <= 1'b1;
    end
  end

  assign status.second_pending = pending;

endmodule
`default_nettype wire

@@ rtl/two_key_rollover_filter_top.sv @@
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   cmd, key_index
// output    out        out_valid / out_stall event_kind, out_key, accepted, last
// config    APB        psel, penable, pwrite paddr[3:0], pwdata / prdata (64 bits)
//
// An item is taken, then shows one result, or two in turn; the controller
// handles one item at a time.
// Synchronous reset clears the held set, count and recognized key, and sets
// the present mask to all ones. A stalled result holds in the output register
// and the input stalls until the last result of the item is taken.
`default_nettype none
module two_key_rollover_filter_top import tkr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              cmd,
  input  wire logic [KEY_W-1:0]  key_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             event_kind,
  output logic [KEY_W-1:0]       out_key,
  output logic                   accepted,
  output logic                   last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;
  logic              cfg_write;
  logic [DATA_W-1:0] key_mask;

  // Decode the register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[3] == REG_KEY_MASK);
  assign prdata    = (paddr[3] == REG_KEY_MASK) ? key_mask : '0;

  tkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd_o     (dp_cmd)
  );

  tkr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd_i      (dp_cmd),
    .status     (dp_status),
    .cfg_write  (cfg_write),
    .cfg_data   (pwdata),
    .key_mask   (key_mask),
    .cmd        (cmd),
    .key_index  (key_index),
    .event_kind (event_kind),
    .out_key    (out_key),
    .accepted   (accepted),
    .last       (last)
  );

  // A taken item shows its first result in the next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("taken item did not produce a result");

  // A result without last is followed by the reported press
  a_second_is_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && event_kind == EV_PRESS && last)
    else $error("second result is not a final press");

  // No new item is taken while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // A rejected event reports nothing and ends its run
  a_reject_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> event_kind == EV_NONE && last && out_key == '0)
    else $error("rejected event reported something");

endmodule
`default_nettype wire
